// ===== rtl/sync_len_sum_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// sync_len_sum_frame_parser_macros
// Assertion macros used by the frame parser top level.
// ----------------------------------------------------------------------------
`ifndef SYNC_LEN_SUM_FRAME_PARSER_MACROS_SVH
`define SYNC_LEN_SUM_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLSFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLSFP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slsfp_pkg
// Types and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slsfp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_SYNC_FIRST  = 3'd0;
  localparam logic [2:0] CFG_SYNC_SECOND = 3'd1;
  localparam logic [2:0] CFG_CHANNEL_A   = 3'd2;
  localparam logic [2:0] CFG_CHANNEL_B   = 3'd3;
  localparam logic [2:0] CFG_CHANNEL_C   = 3'd4;

  localparam logic [7:0] RST_SYNC_FIRST  = 8'd0;
  localparam logic [7:0] RST_SYNC_SECOND = 8'd0;
  localparam logic [7:0] RST_CHANNEL_A   = 8'd0;
  localparam logic [7:0] RST_CHANNEL_B   = 8'd1;
  localparam logic [7:0] RST_CHANNEL_C   = 8'd2;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] channel_a;
    logic [7:0] channel_b;
    logic [7:0] channel_c;
  } cfg_t;

  // One checked frame waiting for emission
  typedef struct packed {
    logic       bank;
    logic       empty;
    logic [6:0] count;
    logic [7:0] channel;
    logic [7:0] length;
  } desc_t;

  // Payload store write port
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [5:0] idx;
    logic [7:0] data;
  } wr_t;

  // Bank handed back by the emitter
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

// ===== rtl/slsfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// slsfp_byte_if
// Received byte channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/slsfp_frame_if.sv =====
// ----------------------------------------------------------------------------
// slsfp_frame_if
// Result channel, one payload byte of a good frame per transfer, or one marker transfer for an empty payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slsfp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel;
  logic [7:0] frame_length;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       last;
  logic       empty_payload;

  modport source (output valid, output channel, output frame_length, output data_byte,
                  output byte_index, output last, output empty_payload, input ready);
  modport sink (input valid, input channel, input frame_length, input data_byte,
                input byte_index, input last, input empty_payload, output ready);
endinterface

// ===== rtl/slsfp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// slsfp_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slsfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/slsfp_front.sv =====
// ----------------------------------------------------------------------------
// slsfp_front
// Byte parser: sync hunt, channel/length decode, payload write, checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slsfp_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                clk,
  input  logic                rst,
  slsfp_byte_if.sink          rx,
  slsfp_cfg_if.sink           cfg,
  input  logic                q_full,
  input  slsfp_pkg::rel_t     rel,
  output logic                q_push,
  output slsfp_pkg::desc_t    q_desc,
  output slsfp_pkg::wr_t      wr
);

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_CHAN  = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;
  localparam logic [6:0] MAX_CNT  = 7'(MAX_PAYLOAD);

  slsfp_pkg::cfg_t cfg_regs;

  logic [2:0] phase, phase_next;
  logic [7:0] held_channel, held_channel_next;
  logic [7:0] held_length, held_length_next;
  logic [6:0] stored_count, stored_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic       wbank, wbank_next;
  logic [1:0] busy, busy_next;

  logic       accept;
  logic [7:0] b;
  logic [6:0] cnt_inc;
  logic       chan_hit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.sync_first  <= slsfp_pkg::RST_SYNC_FIRST;
      cfg_regs.sync_second <= slsfp_pkg::RST_SYNC_SECOND;
      cfg_regs.channel_a   <= slsfp_pkg::RST_CHANNEL_A;
      cfg_regs.channel_b   <= slsfp_pkg::RST_CHANNEL_B;
      cfg_regs.channel_c   <= slsfp_pkg::RST_CHANNEL_C;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        slsfp_pkg::CFG_SYNC_FIRST:  cfg_regs.sync_first  <= cfg.data;
        slsfp_pkg::CFG_SYNC_SECOND: cfg_regs.sync_second <= cfg.data;
        slsfp_pkg::CFG_CHANNEL_A:   cfg_regs.channel_a   <= cfg.data;
        slsfp_pkg::CFG_CHANNEL_B:   cfg_regs.channel_b   <= cfg.data;
        slsfp_pkg::CFG_CHANNEL_C:   cfg_regs.channel_c   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Hold off a payload byte while its bank is still being emitted, and the
  // checksum byte while the descriptor queue has no room.
  assign rx.ready = !((phase == PH_DATA) && busy[wbank]) && !((phase == PH_SUM) && q_full);
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign cnt_inc  = stored_count + 7'd1;
  assign chan_hit = (b == cfg_regs.channel_a) || (b == cfg_regs.channel_b) ||
                    (b == cfg_regs.channel_c);

  always_comb begin
    phase_next        = phase;
    held_channel_next = held_channel;
    held_length_next  = held_length;
    stored_count_next = stored_count;
    running_sum_next  = running_sum;
    wbank_next        = wbank;
    busy_next         = busy;
    q_push            = 1'b0;
    wr.en             = 1'b0;
    wr.bank           = wbank;
    wr.idx            = stored_count[5:0];
    wr.data           = b;

    q_desc.bank    = wbank;
    q_desc.empty   = (stored_count == 7'd0);
    q_desc.count   = stored_count;
    q_desc.channel = held_channel;
    q_desc.length  = held_length;

    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end

    if (accept) begin
      unique case (phase)
        PH_SYNC2: begin
          if (b == cfg_regs.sync_second) begin
            phase_next = PH_CHAN;
          end else if (b == cfg_regs.sync_first) begin
            phase_next = PH_SYNC2;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_CHAN: begin
          if (chan_hit) begin
            held_channel_next = b;
            running_sum_next  = b;
            phase_next        = PH_LEN;
          end else if (b == cfg_regs.sync_first) begin
            phase_next = PH_SYNC2;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_LEN: begin
          held_length_next  = b;
          stored_count_next = 7'd0;
          running_sum_next  = running_sum + b;
          phase_next        = (b == 8'd0) ? PH_SUM : PH_DATA;
        end
        PH_DATA: begin
          wr.en             = 1'b1;
          stored_count_next = cnt_inc;
          running_sum_next  = running_sum + b;
          if (({1'b0, cnt_inc} >= held_length) || (cnt_inc >= MAX_CNT)) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_next = PH_SYNC1;
          if (b == running_sum) begin
            q_push = 1'b1;
            if (stored_count != 7'd0) begin
              busy_next[wbank] = 1'b1;
              wbank_next       = !wbank;
            end
          end
        end
        default: begin
          phase_next = (b == cfg_regs.sync_first) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      held_channel <= 8'd0;
      held_length  <= 8'd0;
      stored_count <= 7'd0;
      running_sum  <= 8'd0;
      wbank        <= 1'b0;
      busy         <= 2'b00;
    end else begin
      phase        <= phase_next;
      held_channel <= held_channel_next;
      held_length  <= held_length_next;
      stored_count <= stored_count_next;
      running_sum  <= running_sum_next;
      wbank        <= wbank_next;
      busy         <= busy_next;
    end
  end

endmodule

// ===== rtl/slsfp_fifo.sv =====
// ----------------------------------------------------------------------------
// slsfp_fifo
// Two-entry descriptor queue between parser and emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slsfp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slsfp_pkg::desc_t  push_desc,
  input  logic              pop,
  output slsfp_pkg::desc_t  head,
  output logic              not_empty,
  output logic              full
);

  slsfp_pkg::desc_t ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign head      = ent[rptr];
  assign not_empty = (fill != 2'd0);
  assign full      = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/slsfp_back.sv =====
// ----------------------------------------------------------------------------
// slsfp_back
// Emitter: double-banked payload store, read stage and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slsfp_back #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  slsfp_pkg::wr_t    wr,
  input  slsfp_pkg::desc_t  head,
  input  logic              q_valid,
  output logic              pop,
  output slsfp_pkg::rel_t   rel,
  slsfp_frame_if.source     tx
);

  localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;

  logic [5:0] rd_idx;
  logic       issue;
  logic       issue_last;
  logic       out_load;

  logic       p1_valid;
  logic [7:0] p1_channel;
  logic [7:0] p1_length;
  logic [5:0] p1_idx;
  logic       p1_last;
  logic       p1_empty;

  assign out_load   = p1_valid && (!tx.valid || tx.ready);
  assign issue      = q_valid && (!p1_valid || out_load);
  assign issue_last = head.empty || ({1'b0, rd_idx} == (head.count - 7'd1));
  assign pop        = issue && issue_last;
  assign rel.en     = pop && !head.empty;
  assign rel.bank   = head.bank;

  // Read data holds between reads so a stalled read stage keeps its byte.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.idx[IDX_W-1:0]}] <= wr.data;
    end
    if (issue && !head.empty) begin
      rdata <= mem[{head.bank, rd_idx[IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_channel <= head.channel;
      p1_length  <= head.length;
      p1_idx     <= rd_idx;
      p1_last    <= issue_last;
      p1_empty   <= head.empty;
    end
    if (out_load) begin
      tx.channel       <= p1_channel;
      tx.frame_length  <= p1_length;
      tx.data_byte     <= p1_empty ? 8'd0 : rdata;
      tx.byte_index    <= p1_idx;
      tx.last          <= p1_last;
      tx.empty_payload <= p1_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= 6'd0;
      p1_valid <= 1'b0;
      tx.valid <= 1'b0;
    end else begin
      if (issue) begin
        rd_idx <= issue_last ? 6'd0 : rd_idx + 6'd1;
      end
      if (issue) begin
        p1_valid <= 1'b1;
      end else if (out_load) begin
        p1_valid <= 1'b0;
      end
      if (out_load) begin
        tx.valid <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/sync_len_sum_frame_parser.sv =====
// Result path: checksum byte transfer, descriptor queue entry, read stage, output register.
// Throughput: one received byte per cycle and one result per cycle when neither stalls,
//   set by the single write port and single read port of the two-bank payload store.
// Input stalls only while the next payload bank is still being emitted or the
//   two-entry descriptor queue is full.
// Reset: synchronous, active high; clears control state, store contents are left as is.
// ----------------------------------------------------------------------------
// sync_len_sum_frame_parser
// Two-sync-byte frame parser with additive checksum and per-byte frame output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_len_sum_frame_parser_macros.svh"

module sync_len_sum_frame_parser #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic          clk,
  input  logic          rst,
  slsfp_byte_if.sink    rx,
  slsfp_frame_if.source tx,
  slsfp_cfg_if.sink     cfg
);

  // Front end: hunts sync, checks channel, writes payload into the free bank
  // and sums it. A frame whose checksum matches is pushed as a descriptor.
  // Back end: pops descriptors in order, reads the bank one byte per cycle unless
  // the output stalls, and hands the bank back to the front end on the final read.

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  slsfp_pkg::desc_t q_desc;
  slsfp_pkg::desc_t q_head;
  slsfp_pkg::wr_t   wr;
  slsfp_pkg::rel_t  rel;

  slsfp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .cfg    (cfg),
    .q_full (q_full),
    .rel    (rel),
    .q_push (q_push),
    .q_desc (q_desc),
    .wr     (wr)
  );

  // Empty frames use no bank, so the queue can fill; the front end
  // waits on the checksum byte in that case.
  slsfp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  slsfp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .head    (q_head),
    .q_valid (q_valid),
    .pop     (q_pop),
    .rel     (rel),
    .tx      (tx)
  );

  // Checks
  `SLSFP_ASSERT_IMP(a_push_room, clk, rst, q_push, !q_full, "descriptor pushed into full queue")
  `SLSFP_ASSERT_IMP(a_pop_valid, clk, rst, q_pop, q_valid, "descriptor popped from empty queue")
  `SLSFP_ASSERT_IMP(a_bank_owner, clk, rst, wr.en && rel.en, wr.bank != rel.bank,
    "payload written into a bank that is still being read")
  `SLSFP_ASSERT_IMP(a_empty_last, clk, rst, tx.valid && tx.empty_payload, tx.last,
    "empty-payload result not marked last")
  `SLSFP_ASSERT_NXT(a_push_seen, clk, rst, q_push && !q_pop, q_valid,
    "pushed descriptor not visible to the emitter")

endmodule
